// ===== design/ols_pkg.sv =====
package ols_pkg;

  // command codes
  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_READ_ALL  = 3'd1;
  localparam logic [2:0] CMD_DEL_FIRST = 3'd2;
  localparam logic [2:0] CMD_DEL_LAST  = 3'd3;
  localparam logic [2:0] CMD_DEL_POS   = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_NEG   = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] entry_value;
    logic signed [7:0]  position;
  } ols_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic               last;
  } ols_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POST,
    S_READ,
    S_SHIFT
  } ols_state_t;

endpackage

// ===== design/ordered_list_store_unit.sv =====
// Ordered list store: keeps up to CAPACITY signed 32-bit values packed in one
// on-chip memory (one write port, one registered read port), head at entry 0.
// Each input word is one command: append, read out all, delete first, delete
// last or delete at a position; each gives one result word, except a read-out
// of a non-empty list, which gives one word per element with last set on the
// final one. Errors (empty list, negative position, position past the end,
// full store) give a single word and leave the list unchanged; an out-of-range
// position returns the last valid index. Timing: the block takes one command
// at a time. A read-out gives one element per cycle through the memory read
// port while the output drains, when the consumer does not stall it. Delete
// first / delete at position p close the gap by moving each later entry down
// one place, one read and one write per cycle. Results sit in an output
// register, so a stalled consumer only holds the block when it has another
// word to give. The memory needs no clearing after reset: only entries below
// the count are ever read.
module ordered_list_store_unit
  import ols_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ols_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ols_out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // list storage, no reset
  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rdata_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // control state
  ols_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;       // read-out / shift source index
  logic [2:0]       post_status_r, post_status_nxt;
  logic [31:0]      post_value_r, post_value_nxt;

  // output register
  logic             out_valid_r;
  ols_out_t         out_r;
  logic             out_load;
  ols_out_t         out_nxt;

  // decode helpers
  logic             accept;
  logic             slot_free;
  logic             is_empty;
  logic             is_full;
  logic             is_neg;
  logic             is_range;
  logic             cmd_unknown;
  logic [CNT_W-1:0] del_start;
  logic [CNT_W-1:0] sh_first;
  logic             no_shift;
  logic [CNT_W-1:0] idx_inc;
  logic             idx_at_end;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == CNT_W'(CAPACITY));
  assign is_neg      = in_data.position[7];
  assign is_range    = ({1'b0, in_data.position[6:0]} >= 8'(count_r));
  assign cmd_unknown = (in_data.cmd > CMD_DEL_POS);

  // element removed: head for delete first, else the given position
  assign del_start = (in_data.cmd == CMD_DEL_FIRST) ? '0 : CNT_W'(in_data.position[6:0]);
  assign sh_first  = del_start + CNT_W'(1);
  assign no_shift  = (sh_first == count_r);

  assign idx_inc    = idx_r + CNT_W'(1);
  assign idx_at_end = (idx_inc == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_READ_ALL && !is_empty) begin
            state_nxt = S_READ;
          end else if ((in_data.cmd == CMD_DEL_FIRST ||
                        (in_data.cmd == CMD_DEL_POS && !is_neg && !is_range)) &&
                       !is_empty && !no_shift) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_POST;
          end
        end
      end
      S_POST: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free && idx_at_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (idx_at_end) begin
          state_nxt = S_POST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = count_r[IDX_W-1:0];
    mem_wdata       = in_data.entry_value;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    post_status_nxt = post_status_r;
    post_value_nxt  = post_value_r;
    out_load        = 1'b0;
    out_nxt         = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          post_status_nxt = ST_OK;
          post_value_nxt  = '0;
          if (in_data.cmd == CMD_APPEND) begin
            if (is_full) begin
              post_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (cmd_unknown) begin
            post_status_nxt = ST_OK;
          end else if (is_empty) begin
            post_status_nxt = ST_EMPTY;
          end else begin
            unique case (in_data.cmd)
              CMD_READ_ALL: begin
                mem_re  = 1'b1;
                idx_nxt = '0;
              end
              CMD_DEL_LAST: begin
                count_nxt = count_r - CNT_W'(1);
              end
              CMD_DEL_FIRST, CMD_DEL_POS: begin
                if (in_data.cmd == CMD_DEL_POS && is_neg) begin
                  post_status_nxt = ST_NEG;
                end else if (in_data.cmd == CMD_DEL_POS && is_range) begin
                  post_status_nxt = ST_RANGE;
                  post_value_nxt  = 32'(count_r) - 32'd1;
                end else if (no_shift) begin
                  // removing the tail, nothing to move
                  count_nxt = count_r - CNT_W'(1);
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = sh_first[IDX_W-1:0];
                  idx_nxt   = sh_first;
                end
              end
              default: begin
                post_status_nxt = ST_OK;
              end
            endcase
          end
        end
      end
      S_POST: begin
        if (slot_free) begin
          out_load           = 1'b1;
          out_nxt.status     = post_status_r;
          out_nxt.read_value = post_value_r;
          out_nxt.last       = 1'b1;
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_load           = 1'b1;
          out_nxt.status     = ST_OK;
          out_nxt.read_value = rdata_r;
          out_nxt.last       = idx_at_end;
          if (!idx_at_end) begin
            // fetch the next element while this one goes out
            mem_re    = 1'b1;
            mem_raddr = idx_inc[IDX_W-1:0];
            idx_nxt   = idx_inc;
          end
        end
      end
      S_SHIFT: begin
        // move the entry read last cycle down one place
        mem_we    = 1'b1;
        mem_waddr = idx_r[IDX_W-1:0] - IDX_W'(1);
        mem_wdata = rdata_r;
        if (idx_at_end) begin
          count_nxt       = count_r - CNT_W'(1);
          post_status_nxt = ST_OK;
          post_value_nxt  = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
          idx_nxt   = idx_inc;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // storage: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    post_status_r <= post_status_nxt;
    post_value_r  <= post_value_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== design/ols_checker.sv =====
module ols_port_checks
  import ols_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ols_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ols_out_t out_data
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while another is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FULL)
    else $error("status code out of range");

  // only read-out words come before the last one, and they are ok
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK)
    else $error("error status on a non-final word");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY || out_data.status == ST_NEG ||
                  out_data.status == ST_FULL) |-> out_data.read_value == '0)
    else $error("error word carries a value");

endmodule

bind ordered_list_store_unit ols_port_checks u_ols_checker (.*);
